### sv/ucdbk_pkg.sv
`timescale 1ns / 1ps
// Package for the USB configuration descriptor boot keyboard scanner.
// Holds the word types of both channels and the descriptor field codes.
// No dependencies.
package ucdbk_pkg;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        first_byte;
    logic [15:0] total_length;
  } in_word_t;

  typedef struct packed {
    logic       keyboard_found;
    logic       endpoint_ready;
    logic [7:0] endpoint_address;
    logic [7:0] poll_interval;
    logic       malformed;
    logic       complete;
  } out_word_t;

  localparam logic [7:0] TYPE_INTERFACE    = 8'd4;
  localparam logic [7:0] TYPE_ENDPOINT     = 8'd5;
  localparam logic [7:0] CLASS_HID         = 8'd3;
  localparam logic [7:0] BOOT_SUBCLASS     = 8'd1;
  localparam logic [7:0] KEYBOARD_PROTOCOL = 8'd1;
  localparam logic [1:0] XFER_INTERRUPT    = 2'd3;
  localparam int         DIR_IN_BIT        = 7;

  // Descriptor offsets whose bytes are kept until the descriptor ends.
  localparam logic [7:0] OFS_TYPE     = 8'd1;
  localparam logic [7:0] OFS_FIELD2   = 8'd2;
  localparam logic [7:0] OFS_FIELD3   = 8'd3;
  localparam logic [7:0] OFS_FIELD5   = 8'd5;
  localparam logic [7:0] OFS_FIELD6   = 8'd6;
  localparam logic [7:0] OFS_FIELD7   = 8'd7;

endpackage

### sv/usb_config_descriptor_boot_keyboard_scan.sv
`timescale 1ns / 1ps
// A word accepted into the input register is parsed combinationally, and its result
// is then taken into the result register, from which it shows on the ports.
// Throughput: one word per cycle unless out_stall holds a full result register; the
// parse update between the two registers is combinational. Reset (rst_n low,
// synchronous) empties both registers and clears all parse state, which is the
// same as the start of a new descriptor set. Depends on ucdbk_pkg.
module usb_config_descriptor_boot_keyboard_scan
  import ucdbk_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_data
);

  logic      s1_valid_r;
  in_word_t  s1_word_r;
  logic      out_valid_r;
  out_word_t out_word_r;
  logic      s1_adv;

  logic [15:0] pos_r, pos_nxt;
  logic [7:0]  ofs_r, ofs_nxt;
  logic [7:0]  dlen_r, dlen_nxt;
  logic [7:0]  kind_r, kind_nxt;
  logic [7:0]  cap_r [5];
  logic [7:0]  cap_nxt [5];
  logic        kbd_r, kbd_nxt;
  logic        ep_r, ep_nxt;
  logic [7:0]  addr_r, addr_nxt;
  logic [7:0]  intv_r, intv_nxt;
  logic        err_r, err_nxt;
  logic        stop_r, stop_nxt;
  out_word_t   res;

  // The input register moves on whenever the result register is free or drains.
  assign s1_adv   = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !s1_adv;

  always_comb begin
    logic [7:0]  b;
    logic [15:0] total;
    logic [7:0]  ofs_inc;
    logic        finish;
    b        = s1_word_r.data_byte;
    total    = s1_word_r.total_length;
    pos_nxt  = pos_r;
    ofs_nxt  = ofs_r;
    dlen_nxt = dlen_r;
    kind_nxt = kind_r;
    for (int i = 0; i < 5; i++) cap_nxt[i] = cap_r[i];
    kbd_nxt  = kbd_r;
    ep_nxt   = ep_r;
    addr_nxt = addr_r;
    intv_nxt = intv_r;
    err_nxt  = err_r;
    stop_nxt = stop_r;
    finish   = 1'b0;
    ofs_inc  = 8'd0;

    if (s1_word_r.first_byte) begin
      pos_nxt  = '0;
      ofs_nxt  = '0;
      dlen_nxt = '0;
      kind_nxt = '0;
      for (int i = 0; i < 5; i++) cap_nxt[i] = '0;
      kbd_nxt  = 1'b0;
      ep_nxt   = 1'b0;
      addr_nxt = '0;
      intv_nxt = '0;
      err_nxt  = 1'b0;
      stop_nxt = 1'b0;
    end

    if (!stop_nxt && pos_nxt < total) begin
      ofs_inc = ofs_nxt + 8'd1;
      if (ofs_nxt == 8'd0) begin
        // A length byte: zero or an overrun of the set ends the parse.
        if (b == 8'd0 || ({1'b0, pos_nxt} + {9'd0, b}) > {1'b0, total}) begin
          err_nxt  = 1'b1;
          stop_nxt = 1'b1;
        end else begin
          dlen_nxt = b;
          kind_nxt = '0;
          for (int i = 0; i < 5; i++) cap_nxt[i] = '0;
          pos_nxt  = pos_nxt + 16'd1;
          ofs_nxt  = ofs_inc;
          finish   = (ofs_inc >= b);
        end
      end else begin
        case (ofs_nxt)
          OFS_TYPE:   kind_nxt   = b;
          OFS_FIELD2: cap_nxt[0] = b;
          OFS_FIELD3: cap_nxt[1] = b;
          OFS_FIELD5: cap_nxt[2] = b;
          OFS_FIELD6: cap_nxt[3] = b;
          OFS_FIELD7: cap_nxt[4] = b;
          default: ;
        endcase
        pos_nxt = pos_nxt + 16'd1;
        ofs_nxt = ofs_inc;
        finish  = (ofs_inc >= dlen_nxt);
      end
    end

    if (finish) begin
      if (kind_nxt == TYPE_INTERFACE) begin
        if (cap_nxt[2] == CLASS_HID && cap_nxt[3] == BOOT_SUBCLASS &&
            cap_nxt[4] == KEYBOARD_PROTOCOL) begin
          kbd_nxt = 1'b1;
        end
      end else if (kind_nxt == TYPE_ENDPOINT) begin
        if (kbd_nxt && !ep_nxt && cap_nxt[1][1:0] == XFER_INTERRUPT &&
            cap_nxt[0][DIR_IN_BIT]) begin
          ep_nxt   = 1'b1;
          addr_nxt = cap_nxt[0];
          intv_nxt = cap_nxt[3];
        end
      end
      ofs_nxt = '0;
    end

    res.keyboard_found   = kbd_nxt;
    res.endpoint_ready   = ep_nxt;
    res.endpoint_address = addr_nxt;
    res.poll_interval    = intv_nxt;
    res.malformed        = err_nxt;
    res.complete         = stop_nxt || (pos_nxt >= total);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
    if (!in_stall && in_valid) begin
      s1_word_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
    if (s1_adv) begin
      out_word_r <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      ofs_r  <= '0;
      dlen_r <= '0;
      kind_r <= '0;
      for (int i = 0; i < 5; i++) cap_r[i] <= '0;
      kbd_r  <= 1'b0;
      ep_r   <= 1'b0;
      addr_r <= '0;
      intv_r <= '0;
      err_r  <= 1'b0;
      stop_r <= 1'b0;
    end else if (s1_adv) begin
      pos_r  <= pos_nxt;
      ofs_r  <= ofs_nxt;
      dlen_r <= dlen_nxt;
      kind_r <= kind_nxt;
      for (int i = 0; i < 5; i++) cap_r[i] <= cap_nxt[i];
      kbd_r  <= kbd_nxt;
      ep_r   <= ep_nxt;
      addr_r <= addr_nxt;
      intv_r <= intv_nxt;
      err_r  <= err_nxt;
      stop_r <= stop_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_word_r;

endmodule

### sv/ucdbk_chk.sv
`timescale 1ns / 1ps
// Port-level checker for the boot keyboard descriptor scanner, with its bind.
// Depends on ucdbk_pkg and the top level usb_config_descriptor_boot_keyboard_scan.
module ucdbk_chk
  import ucdbk_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      out_valid,
  input logic      out_stall,
  input out_word_t out_data
);

  // A stalled result word stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result word changed while stalled");

  // A malformed set always ends the parse.
  a_malformed_complete: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.malformed |-> out_data.complete)
    else $error("malformed set not marked complete");

  // An endpoint is only ever recorded after a keyboard interface.
  a_ep_needs_kbd: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.endpoint_ready |-> out_data.keyboard_found)
    else $error("endpoint recorded without keyboard interface");

  // Until an endpoint is recorded, address and interval read as zero.
  a_ep_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.endpoint_ready |->
      out_data.endpoint_address == 8'd0 && out_data.poll_interval == 8'd0)
    else $error("endpoint fields set before an endpoint was recorded");

endmodule

bind usb_config_descriptor_boot_keyboard_scan ucdbk_chk u_ucdbk_chk (.*);
